@@ hdl/pcf_pkg.sv @@
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and codes of the chain force block: configuration register
// indexes, controller states, datapath operations and the control bundles.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HARMONIC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUBIC    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTIC  = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOAD   = 8'b0000_0010,
    ST_MSTART = 8'b0000_0100,
    ST_MWAIT  = 8'b0000_1000,
    ST_ABS    = 8'b0001_0000,
    ST_SETUP  = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_A,
    OP_LOAD_B,
    OP_MUL_START,
    OP_ABS,
    OP_SETUP,
    OP_DIV,
    OP_OUT
  } dp_op_e;

  typedef enum logic [2:0] {
    MS_Q1,
    MS_Q2,
    MS_C1,
    MS_C2,
    MS_T1,
    MS_T2,
    MS_T3
  } mul_step_e;

  localparam mul_step_e MS_LAST = MS_T3;

  typedef struct packed {
    logic      accept;
    dp_op_e    op;
    mul_step_e mstep;
  } dp_cmd_t;

  typedef struct packed {
    logic need_a;
    logic need_b;
    logic mul_done;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/pcf_mul.sv @@
// ----------------------------------------------------------------------------
// pcf_mul
// Shared serial multiplier: wide signed multiplicand times a signed
// multiplier, four multiplier bits a cycle, lowest digit first.
// ----------------------------------------------------------------------------
module pcf_mul #(
  parameter int unsigned NP = 168,
  parameter int unsigned WB = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NP-1:0] a_i,
  input  logic signed [WB-1:0] b_i,
  output logic signed [NP-1:0] p_o,
  output logic                 done_o
);

  localparam int unsigned DIG = (WB + 3) / 4;
  localparam int unsigned NB  = DIG * 4;
  localparam int unsigned CW  = (DIG > 1) ? $clog2(DIG) : 1;

  logic signed [NP-1:0] a_q;
  logic        [NB-1:0] b_q;
  logic signed [NP-1:0] p_q;
  logic        [CW-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic signed [4:0]    dsig;
  logic signed [NP-1:0] pp;

  always_comb begin
    if (cnt_q == '0) begin
      dsig = $signed({b_q[3], b_q[3:0]});
    end else begin
      dsig = $signed({1'b0, b_q[3:0]});
    end
  end

  assign pp = a_q * dsig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIG - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= NB'(b_i);
      p_q <= '0;
    end else if (busy_q) begin
      p_q <= p_q + pp;
      a_q <= a_q <<< 4;
      b_q <= b_q >> 4;
    end
  end

  assign p_o    = p_q;
  assign done_o = done_q;

endmodule

@@ hdl/pcf_dp.sv @@
// ----------------------------------------------------------------------------
// pcf_dp
// Datapath: coefficient registers, the held particle, job operands, the
// polynomial numerator, the restoring divider and the result register.
// ----------------------------------------------------------------------------
module pcf_dp
  import pcf_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [DATA_WIDTH-1:0] cfg_wdata_i,
  input  logic [DATA_WIDTH-1:0] position_i,
  input  logic [DATA_WIDTH-1:0] mass_i,
  input  logic                  is_first_i,
  input  logic                  is_last_i,
  input  logic [DATA_WIDTH-1:0] left_boundary_stretch_i,
  input  logic [DATA_WIDTH-1:0] right_boundary_stretch_i,
  input  logic                  out_stall_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  output logic [DATA_WIDTH-1:0] acceleration_o,
  output logic                  saturated_o,
  output logic                  chain_end_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned WB = W + 1;
  localparam int unsigned NP = (F > W) ? (2 * W + 2 * F + 8) : (4 * W + 8);
  localparam int unsigned CW = $clog2(W);
  localparam logic [W-1:0] K3_RESET = {{(W-1){1'b0}}, 1'b1} << F;
  localparam logic [W-1:0] POS_MAX  = {1'b0, {(W-1){1'b1}}};

  logic signed [W-1:0]  k1_q, k2_q, k3_q;
  logic signed [W-1:0]  held_pos_q;
  logic        [W-1:0]  held_mass_q;
  logic signed [WB-1:0] held_ls_q;
  logic                 held_valid_q;

  logic signed [WB-1:0] ja_d1_q, ja_d2_q, jb_d1_q, jb_d2_q;
  logic        [W-1:0]  ja_mass_q, jb_mass_q;

  logic signed [WB-1:0] d1_q, d2_q;
  logic        [W-1:0]  mass_q;
  logic                 end_q;
  logic signed [NP-1:0] q1_q, q2_q, s3_q, num_q;
  logic        [NP-1:0] mag_q;
  logic                 neg_q, nz_q, early_q;
  logic        [W-1:0]  rem_q, lo_q, quo_q;
  logic        [CW-1:0] cnt_q;

  logic                 out_valid_q, sat_q, chain_end_q;
  logic        [W-1:0]  acc_q;

  logic signed [WB-1:0] pos_x, hpos_x, d1_new;
  logic                 need_a;
  logic signed [NP-1:0] mul_a;
  logic signed [WB-1:0] mul_b;
  logic signed [NP-1:0] prod;
  logic                 mul_done;
  logic        [W:0]    r2;
  logic                 r2_ge;
  logic        [W-1:0]  limit, qv, acc_d;
  logic                 zero_case, sat_d;

  assign pos_x  = WB'($signed(position_i));
  assign hpos_x = WB'(held_pos_q);
  assign need_a = held_valid_q && !is_first_i;
  assign d1_new = need_a ? (pos_x - hpos_x) : WB'($signed(left_boundary_stretch_i));

  always_comb begin
    case (cmd_i.mstep)
      MS_Q1: begin
        mul_a = NP'(d1_q);
        mul_b = d1_q;
      end
      MS_Q2: begin
        mul_a = NP'(d2_q);
        mul_b = d2_q;
      end
      MS_C1: begin
        mul_a = q1_q;
        mul_b = d1_q;
      end
      MS_C2: begin
        mul_a = q2_q;
        mul_b = d2_q;
      end
      MS_T1: begin
        mul_a = NP'(d1_q) + NP'(d2_q);
        mul_b = WB'(k1_q);
      end
      MS_T2: begin
        mul_a = q2_q - q1_q;
        mul_b = WB'(k2_q);
      end
      MS_T3: begin
        mul_a = s3_q;
        mul_b = WB'(k3_q);
      end
      default: begin
        mul_a = NP'(d1_q);
        mul_b = d1_q;
      end
    endcase
  end

  pcf_mul #(
    .NP(NP),
    .WB(WB)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.op == OP_MUL_START),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .p_o    (prod),
    .done_o (mul_done)
  );

  assign r2    = {rem_q, lo_q[W-1]};
  assign r2_ge = r2 >= {1'b0, mass_q};

  assign limit     = POS_MAX + W'(neg_q);
  assign zero_case = (mass_q == '0) && !nz_q;
  assign sat_d     = !zero_case && (early_q || (quo_q > limit));
  assign qv        = zero_case ? '0 : (sat_d ? limit : quo_q);
  assign acc_d     = neg_q ? (~qv + 1'b1) : qv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q         <= '0;
      k2_q         <= '0;
      k3_q         <= K3_RESET;
      held_pos_q   <= '0;
      held_mass_q  <= '0;
      held_ls_q    <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HARMONIC: k1_q <= cfg_wdata_i;
          CFG_CUBIC:    k2_q <= cfg_wdata_i;
          CFG_QUARTIC:  k3_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        held_valid_q <= !is_last_i;
        if (!is_last_i) begin
          held_pos_q  <= position_i;
          held_mass_q <= mass_i;
          held_ls_q   <= d1_new;
        end
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ja_d1_q   <= held_ls_q;
      ja_d2_q   <= hpos_x - pos_x;
      ja_mass_q <= held_mass_q;
      jb_d1_q   <= d1_new;
      jb_d2_q   <= WB'($signed(right_boundary_stretch_i));
      jb_mass_q <= mass_i;
    end
    if (mul_done) begin
      case (cmd_i.mstep)
        MS_Q1:   q1_q  <= prod;
        MS_Q2:   q2_q  <= prod;
        MS_C1:   s3_q  <= prod;
        MS_C2:   s3_q  <= s3_q + prod;
        MS_T1:   num_q <= -(prod <<< (2 * F + 1));
        MS_T2:   num_q <= num_q + (prod <<< F) + (prod <<< (F + 1));
        MS_T3:   num_q <= num_q - (prod <<< 2);
        default: ;
      endcase
    end
    case (cmd_i.op)
      OP_LOAD_A: begin
        d1_q   <= ja_d1_q;
        d2_q   <= ja_d2_q;
        mass_q <= ja_mass_q;
        end_q  <= 1'b0;
      end
      OP_LOAD_B: begin
        d1_q   <= jb_d1_q;
        d2_q   <= jb_d2_q;
        mass_q <= jb_mass_q;
        end_q  <= 1'b1;
      end
      OP_ABS: begin
        neg_q <= num_q[NP-1];
        mag_q <= num_q[NP-1] ? (~num_q + 1'b1) : num_q;
      end
      OP_SETUP: begin
        nz_q    <= mag_q != '0;
        early_q <= (mass_q == '0) ? (mag_q != '0)
                                  : (mag_q[NP-1:2*F+W] >= (NP-2*F-W)'(mass_q));
        rem_q   <= mag_q[2*F+2*W-1:2*F+W];
        lo_q    <= mag_q[2*F+W-1:2*F];
        quo_q   <= '0;
        cnt_q   <= CW'(W - 1);
      end
      OP_DIV: begin
        rem_q <= r2_ge ? W'(r2 - {1'b0, mass_q}) : r2[W-1:0];
        lo_q  <= lo_q << 1;
        quo_q <= {quo_q[W-2:0], r2_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      OP_OUT: begin
        acc_q       <= acc_d;
        sat_q       <= sat_d;
        chain_end_q <= end_q;
      end
      default: ;
    endcase
  end

  assign status_o.need_a   = need_a;
  assign status_o.need_b   = is_last_i;
  assign status_o.mul_done = mul_done;
  assign status_o.div_last = cnt_q == '0;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign acceleration_o = acc_q;
  assign saturated_o    = sat_q;
  assign chain_end_o    = chain_end_q;

endmodule

@@ hdl/pcf_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcf_ctrl
// Controller: accepts a particle, queues up to two result jobs and steps
// the datapath through multiply, magnitude, divide and output phases.
// ----------------------------------------------------------------------------
module pcf_ctrl
  import pcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  mul_step_e   mstep_q, mstep_d;
  logic        pend_a_q, pend_a_d;
  logic        pend_b_q, pend_b_d;

  always_comb begin
    state_d      = state_q;
    mstep_d      = mstep_q;
    pend_a_d     = pend_a_q;
    pend_b_d     = pend_b_q;
    cmd_o.accept = 1'b0;
    cmd_o.op     = OP_NONE;
    cmd_o.mstep  = mstep_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          pend_a_d     = status_i.need_a;
          pend_b_d     = status_i.need_b;
          if (status_i.need_a || status_i.need_b) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (pend_a_q) begin
          cmd_o.op = OP_LOAD_A;
          pend_a_d = 1'b0;
        end else begin
          cmd_o.op = OP_LOAD_B;
          pend_b_d = 1'b0;
        end
        mstep_d = MS_Q1;
        state_d = ST_MSTART;
      end
      ST_MSTART: begin
        cmd_o.op = OP_MUL_START;
        state_d  = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (status_i.mul_done) begin
          if (mstep_q == MS_LAST) begin
            state_d = ST_ABS;
          end else begin
            mstep_d = mul_step_e'(mstep_q + 1'b1);
            state_d = ST_MSTART;
          end
        end
      end
      ST_ABS: begin
        cmd_o.op = OP_ABS;
        state_d  = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.op = OP_SETUP;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (status_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = (pend_a_q || pend_b_q) ? ST_LOAD : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mstep_q  <= MS_Q1;
      pend_a_q <= 1'b0;
      pend_b_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mstep_q  <= mstep_d;
      pend_a_q <= pend_a_d;
      pend_b_q <= pend_b_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule

@@ hdl/polynomial_chain_force.sv @@
// ----------------------------------------------------------------------------
// polynomial_chain_force
// Acceleration of particles of a one-dimensional chain with springs of
// second, third and fourth order, in signed fixed point.
// ----------------------------------------------------------------------------
// Particles enter left to right on the input channel (in_valid_i/in_stall_o);
// a transaction moves position, mass, chain markers and the boundary
// stretches. The block holds one particle until its right neighbour arrives,
// then returns its acceleration on the output channel (out_valid_o/
// out_stall_i). A last particle that follows a held one gives two results,
// the held particle's first.
// Each result takes seven products through one shared multiplier that
// takes four multiplier bits a cycle, then a restoring divider by mass that
// yields one quotient bit a cycle. An input transaction is taken only while
// no result is being worked; a particle that gives no result is taken
// without leaving the idle state.
// The output register holds a result while the receiver stalls; the block
// takes the next particle meanwhile and waits before its own output step.
// Reset clears the held particle and sets the coefficients to 0, 0 and 1.0.
// Coefficients are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
// must do so only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module polynomial_chain_force
  import pcf_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [DATA_WIDTH-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_WIDTH-1:0] position_i,
  input  logic [DATA_WIDTH-1:0] mass_i,
  input  logic                  is_first_i,
  input  logic                  is_last_i,
  input  logic [DATA_WIDTH-1:0] left_boundary_stretch_i,
  input  logic [DATA_WIDTH-1:0] right_boundary_stretch_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] acceleration_o,
  output logic                  saturated_o,
  output logic                  chain_end_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pcf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pcf_dp #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .position_i              (position_i),
    .mass_i                  (mass_i),
    .is_first_i              (is_first_i),
    .is_last_i               (is_last_i),
    .left_boundary_stretch_i (left_boundary_stretch_i),
    .right_boundary_stretch_i(right_boundary_stretch_i),
    .out_stall_i             (out_stall_i),
    .cmd_i                   (cmd),
    .status_o                (status),
    .out_valid_o             (out_valid_o),
    .acceleration_o          (acceleration_o),
    .saturated_o             (saturated_o),
    .chain_end_o             (chain_end_o)
  );

endmodule

@@ hdl/pcf_checker.sv @@
// ----------------------------------------------------------------------------
// pcf_checker
// Port-level checks of the chain force block, bound to its top level.
// ----------------------------------------------------------------------------
module pcf_checker
  import pcf_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [DATA_WIDTH-1:0] cfg_wdata_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [DATA_WIDTH-1:0] position_i,
  input logic [DATA_WIDTH-1:0] mass_i,
  input logic                  is_first_i,
  input logic                  is_last_i,
  input logic [DATA_WIDTH-1:0] left_boundary_stretch_i,
  input logic [DATA_WIDTH-1:0] right_boundary_stretch_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [DATA_WIDTH-1:0] acceleration_o,
  input logic                  saturated_o,
  input logic                  chain_end_o
);

  localparam logic [DATA_WIDTH-1:0] ACC_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] ACC_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && is_last_i |=> in_stall_o)
    else $error("last particle accepted without starting a result");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> acceleration_o == ACC_MAX || acceleration_o == ACC_MIN)
    else $error("saturated result not at a range limit");

  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a busy phase");

endmodule

bind polynomial_chain_force pcf_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pcf_checker (.*);
